// File: rtl/core/lorf_pkg.sv
// Shared constants, codon codes and pipeline record types for the six-frame ORF scanner.
// No dependencies; imported by every module under rtl/core.
package lorf_pkg;

    localparam int unsigned MAX_SEQ_LEN = 1048576;

    // Byte counter holds the maximum itself; positions and codon indexes stay below it.
    localparam int unsigned CNT_W = $clog2(MAX_SEQ_LEN + 1);
    localparam int unsigned POS_W = $clog2(MAX_SEQ_LEN);
    localparam int unsigned IDX_W = $clog2(MAX_SEQ_LEN / 3 + 1);

    // Result field widths are fixed by the interface.
    localparam int unsigned FRAME_W = 3;
    localparam int unsigned OPOS_W  = 21;
    localparam int unsigned OLEN_W  = 19;

    localparam logic [7:0] CASE_MASK = 8'hDF;
    localparam logic [7:0] NT_A      = 8'h41;
    localparam logic [7:0] NT_C      = 8'h43;
    localparam logic [7:0] NT_G      = 8'h47;
    localparam logic [7:0] NT_T      = 8'h54;

    localparam logic signed [FRAME_W-1:0] FRAME_NONE = '1;

    // A codon mark: v low stands for "none seen".
    typedef struct packed {
        logic             v;
        logic [POS_W-1:0] pos;
        logic [IDX_W-1:0] idx;
    } t_mark;

    // Best ORF of one frame, positions in forward coordinates.
    typedef struct packed {
        logic [IDX_W-1:0] len;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] stop;
    } t_best;

    // Sequence state captured on the last byte.
    typedef struct packed {
        t_best [2:0]      fwd;
        t_mark [2:0]      rstop;
        t_mark [2:0]      rcat;
        t_best [2:0]      rbest;
        logic [CNT_W-1:0] count;
        logic [1:0]       phase;
        logic             ovf;
    } t_snap;

    // Same record after the open reverse segments are closed.
    typedef struct packed {
        t_best [2:0]      fwd;
        t_best [2:0]      rbest;
        logic [CNT_W-1:0] count;
        logic [1:0]       phase;
        logic             ovf;
    } t_closed;

endpackage

// File: rtl/core/longest_orf_six_frame_scan.sv
// Six-frame longest ORF scanner, one sequence byte per word, one result word per sequence.
// Throughput: one byte per cycle while o_stall is low; the codon scan updates all frame state.
// After the last byte is taken the result word passes the scan snapshot, segment close and
// frame selection registers, each stage holding its word while the next is stalled.
// Reset: synchronous, active low; clears the sequence state and every valid flag.
module longest_orf_six_frame_scan (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [7:0]                             i_nucleotide,
    input  logic                                   i_is_last,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_strand,
    output logic signed [lorf_pkg::FRAME_W-1:0]    o_frame,
    output logic signed [lorf_pkg::OPOS_W-1:0]     o_start_pos,
    output logic signed [lorf_pkg::OPOS_W-1:0]     o_end_pos,
    output logic [lorf_pkg::OLEN_W-1:0]            o_length_codons,
    output logic                                   o_too_long
);
    import lorf_pkg::*;

    logic       r_a_valid, r_a_last;
    logic [7:0] r_a_byte;
    logic       r_s_valid, r_c_valid, r_o_valid;

    logic       w_out_free, w_c_free, w_s_free, w_a_go, w_a_free, w_c_move, w_s_move;
    t_snap      w_snap;
    t_closed    w_cls;

    // a stage may take a word when empty or when its own word moves on
    always_comb begin
        w_out_free = !r_o_valid || !i_stall;
        w_c_free   = !r_c_valid || w_out_free;
        w_c_move   = r_c_valid && w_out_free;
        w_s_free   = !r_s_valid || w_c_free;
        w_s_move   = r_s_valid && w_c_free;
        // only the last byte needs room downstream
        w_a_go     = r_a_valid && (!r_a_last || w_s_free);
        w_a_free   = !r_a_valid || w_a_go;
    end

    assign o_stall = !w_a_free;
    assign o_valid = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_a_free) begin
                r_a_valid <= i_valid;
            end
            if (w_s_free) begin
                r_s_valid <= w_a_go && r_a_last;
            end
            if (w_c_free) begin
                r_c_valid <= r_s_valid;
            end
            if (w_out_free) begin
                r_o_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_free && i_valid) begin
            r_a_byte <= i_nucleotide;
            r_a_last <= i_is_last;
        end
    end

    lorf_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_a_go),
        .i_byte  (r_a_byte),
        .i_last  (r_a_last),
        .o_snap  (w_snap)
    );

    lorf_close u_close (
        .i_clk  (i_clk),
        .i_load (w_s_move),
        .i_snap (w_snap),
        .o_cls  (w_cls)
    );

    lorf_pick u_pick (
        .i_clk           (i_clk),
        .i_load          (w_c_move),
        .i_cls           (w_cls),
        .o_strand        (o_strand),
        .o_frame         (o_frame),
        .o_start_pos     (o_start_pos),
        .o_end_pos       (o_end_pos),
        .o_length_codons (o_length_codons),
        .o_too_long      (o_too_long)
    );

endmodule

// File: rtl/core/lorf_scan.sv
// Per-byte codon scan: holds the six-frame sequence state and captures it on the last byte.
// Depends on lorf_pkg.
module lorf_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output lorf_pkg::t_snap o_snap
);
    import lorf_pkg::*;

    logic [15:0]      r_prior, n_prior;
    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       r_phase, n_phase;
    logic [IDX_W-1:0] r_cdiv, n_cdiv;
    t_mark [2:0]      r_fopen, n_fopen;
    t_mark [2:0]      r_rstop, n_rstop;
    t_mark [2:0]      r_rcat, n_rcat;
    t_best [2:0]      r_fbest, n_fbest;
    t_best [2:0]      r_rbest, n_rbest;
    logic             r_ovf, n_ovf;
    t_snap            r_snap;

    logic [7:0]       w_b, w_c0, w_c1;
    logic [1:0]       w_q;
    logic [POS_W-1:0] w_pos;
    logic [IDX_W-1:0] w_idx, w_flen, w_rlen;
    logic             w_atg, w_stop, w_cat, w_rstop;

    always_comb begin
        n_prior = r_prior;
        n_count = r_count;
        n_phase = r_phase;
        n_cdiv  = r_cdiv;
        n_fopen = r_fopen;
        n_rstop = r_rstop;
        n_rcat  = r_rcat;
        n_fbest = r_fbest;
        n_rbest = r_rbest;
        n_ovf   = r_ovf;

        w_b  = i_byte & CASE_MASK;
        w_c0 = r_prior[15:8];
        w_c1 = r_prior[7:0];
        // codon starts two bytes back; its frame is one phase ahead
        w_q   = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
        w_pos = r_count[POS_W-1:0] - POS_W'(2);
        w_idx = (r_phase == 2'd2) ? r_cdiv : r_cdiv - IDX_W'(1);

        w_atg   = (w_c0 == NT_A) && (w_c1 == NT_T) && (w_b == NT_G);
        w_stop  = (w_c0 == NT_T) && (((w_c1 == NT_A) && ((w_b == NT_A) || (w_b == NT_G)))
                                     || ((w_c1 == NT_G) && (w_b == NT_A)));
        w_cat   = (w_c0 == NT_C) && (w_c1 == NT_A) && (w_b == NT_T);
        w_rstop = (w_b == NT_A) && (((w_c0 == NT_T) && ((w_c1 == NT_T) || (w_c1 == NT_C)))
                                    || ((w_c0 == NT_C) && (w_c1 == NT_T)));

        w_flen = w_idx - r_fopen[w_q].idx;
        w_rlen = r_rcat[w_q].idx - r_rstop[w_q].idx;

        if (r_count >= CNT_W'(MAX_SEQ_LEN)) begin
            n_ovf = 1'b1;
        end else begin
            if (r_count >= CNT_W'(2)) begin
                if (w_atg) begin
                    if (!r_fopen[w_q].v) begin
                        n_fopen[w_q] = '{v: 1'b1, pos: w_pos, idx: w_idx};
                    end
                end else if (w_stop) begin
                    if (r_fopen[w_q].v && (w_flen > r_fbest[w_q].len)) begin
                        n_fbest[w_q] = '{len: w_flen, start: r_fopen[w_q].pos, stop: w_pos};
                    end
                    n_fopen[w_q].v = 1'b0;
                end

                if (w_cat) begin
                    n_rcat[w_q] = '{v: 1'b1, pos: w_pos, idx: w_idx};
                end else if (w_rstop) begin
                    // later segments win ties on the reverse strand
                    if (r_rstop[w_q].v && r_rcat[w_q].v && (w_rlen >= r_rbest[w_q].len)) begin
                        n_rbest[w_q] = '{len: w_rlen, start: r_rcat[w_q].pos,
                                         stop: r_rstop[w_q].pos};
                    end
                    n_rstop[w_q]   = '{v: 1'b1, pos: w_pos, idx: w_idx};
                    n_rcat[w_q].v  = 1'b0;
                end
            end
            n_prior = {r_prior[7:0], w_b};
            n_count = r_count + CNT_W'(1);
            n_phase = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
            n_cdiv  = (r_phase == 2'd2) ? r_cdiv + IDX_W'(1) : r_cdiv;
        end
    end

    // clear the sequence state after the last byte as well as at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_last)) begin
            r_prior <= '0;
            r_count <= '0;
            r_phase <= '0;
            r_cdiv  <= '0;
            r_fopen <= '0;
            r_rstop <= '0;
            r_rcat  <= '0;
            r_fbest <= '0;
            r_rbest <= '0;
            r_ovf   <= 1'b0;
        end else if (i_go) begin
            r_prior <= n_prior;
            r_count <= n_count;
            r_phase <= n_phase;
            r_cdiv  <= n_cdiv;
            r_fopen <= n_fopen;
            r_rstop <= n_rstop;
            r_rcat  <= n_rcat;
            r_fbest <= n_fbest;
            r_rbest <= n_rbest;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && i_last) begin
            r_snap <= '{fwd: n_fbest, rstop: n_rstop, rcat: n_rcat, rbest: n_rbest,
                        count: n_count, phase: n_phase, ovf: n_ovf};
        end
    end

    assign o_snap = r_snap;

endmodule

// File: rtl/core/lorf_close.sv
// Closes the open reverse-strand segment of each phase at the end of a sequence.
// Depends on lorf_pkg.
module lorf_close (
    input  logic              i_clk,
    input  logic              i_load,
    input  lorf_pkg::t_snap   i_snap,
    output lorf_pkg::t_closed o_cls
);
    import lorf_pkg::*;

    t_closed                w_cls;
    t_closed                r_cls;
    logic [2:0][IDX_W-1:0]  w_len;

    always_comb begin
        w_cls.fwd   = i_snap.fwd;
        w_cls.rbest = i_snap.rbest;
        w_cls.count = i_snap.count;
        w_cls.phase = i_snap.phase;
        w_cls.ovf   = i_snap.ovf;
        for (int q = 0; q < 3; q++) begin
            w_len[q] = i_snap.rcat[q].idx - i_snap.rstop[q].idx;
            if (i_snap.rstop[q].v && i_snap.rcat[q].v && (w_len[q] >= i_snap.rbest[q].len)) begin
                w_cls.rbest[q] = '{len: w_len[q], start: i_snap.rcat[q].pos,
                                   stop: i_snap.rstop[q].pos};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cls <= w_cls;
        end
    end

    assign o_cls = r_cls;

endmodule

// File: rtl/core/lorf_pick.sv
// Picks the longest ORF over the six frames and maps reverse hits to strand coordinates.
// Depends on lorf_pkg; holds the result word register.
module lorf_pick (
    input  logic                                   i_clk,
    input  logic                                   i_load,
    input  lorf_pkg::t_closed                      i_cls,
    output logic                                   o_strand,
    output logic signed [lorf_pkg::FRAME_W-1:0]    o_frame,
    output logic signed [lorf_pkg::OPOS_W-1:0]     o_start_pos,
    output logic signed [lorf_pkg::OPOS_W-1:0]     o_end_pos,
    output logic [lorf_pkg::OLEN_W-1:0]            o_length_codons,
    output logic                                   o_too_long
);
    import lorf_pkg::*;

    logic [2:0][1:0]             w_rq;
    logic [2:0][2:0]             w_sum;
    logic [IDX_W-1:0]            w_len;
    logic                        w_strand;
    logic signed [FRAME_W-1:0]   w_frame;
    logic signed [OPOS_W-1:0]    w_start, w_stop;

    logic                        r_strand;
    logic signed [FRAME_W-1:0]   r_frame;
    logic signed [OPOS_W-1:0]    r_start, r_stop;
    logic [OLEN_W-1:0]           r_len;
    logic                        r_ovf;

    // reverse frame f reads phase (len mod 3 - f) mod 3
    always_comb begin
        for (int f = 0; f < 3; f++) begin
            w_sum[f] = {1'b0, i_cls.phase} + 3'd3 - 3'(f);
            w_rq[f]  = (w_sum[f] >= 3'd3) ? 2'(w_sum[f] - 3'd3) : w_sum[f][1:0];
        end
    end

    // strict compare: earlier frames keep ties
    always_comb begin
        w_len    = '0;
        w_strand = 1'b0;
        w_frame  = FRAME_NONE;
        w_start  = '1;
        w_stop   = '1;
        for (int f = 0; f < 3; f++) begin
            if (i_cls.fwd[f].len > w_len) begin
                w_len    = i_cls.fwd[f].len;
                w_start  = OPOS_W'(i_cls.fwd[f].start);
                w_stop   = OPOS_W'(i_cls.fwd[f].stop);
                w_frame  = FRAME_W'(f);
                w_strand = 1'b0;
            end
        end
        for (int f = 0; f < 3; f++) begin
            if (i_cls.rbest[w_rq[f]].len > w_len) begin
                w_len    = i_cls.rbest[w_rq[f]].len;
                w_start  = OPOS_W'(i_cls.count - CNT_W'(3) - CNT_W'(i_cls.rbest[w_rq[f]].start));
                w_stop   = OPOS_W'(i_cls.count - CNT_W'(3) - CNT_W'(i_cls.rbest[w_rq[f]].stop));
                w_frame  = FRAME_W'(f);
                w_strand = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_strand <= w_strand;
            r_frame  <= w_frame;
            r_start  <= w_start;
            r_stop   <= w_stop;
            r_len    <= OLEN_W'(w_len);
            r_ovf    <= i_cls.ovf;
        end
    end

    assign o_strand        = r_strand;
    assign o_frame         = r_frame;
    assign o_start_pos     = r_start;
    assign o_end_pos       = r_stop;
    assign o_length_codons = r_len;
    assign o_too_long      = r_ovf;

endmodule

// File: rtl/core/lorf_checker.sv
// Port-level checks on the six-frame ORF scanner result channel.
// Depends on lorf_pkg; bound to longest_orf_six_frame_scan at the end of this file.
module lorf_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   o_valid,
    input  logic                                   i_stall,
    input  logic                                   o_strand,
    input  logic signed [lorf_pkg::FRAME_W-1:0]    o_frame,
    input  logic signed [lorf_pkg::OPOS_W-1:0]     o_start_pos,
    input  logic signed [lorf_pkg::OPOS_W-1:0]     o_end_pos,
    input  logic [lorf_pkg::OLEN_W-1:0]            o_length_codons,
    input  logic                                   o_too_long
);
    import lorf_pkg::*;

    logic [OPOS_W:0] w_span, w_three_len;

    assign w_span      = {o_end_pos[OPOS_W-1], o_end_pos}
                         - {o_start_pos[OPOS_W-1], o_start_pos};
    assign w_three_len = (OPOS_W+1)'({o_length_codons, 1'b0})
                         + (OPOS_W+1)'(o_length_codons);

    // hold a stalled result word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_strand) && $stable(o_frame)
                               && $stable(o_start_pos) && $stable(o_end_pos)
                               && $stable(o_length_codons) && $stable(o_too_long))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    a_none_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_frame == FRAME_NONE) |-> (o_length_codons == '0) && !o_strand
                                              && (o_start_pos == '1) && (o_end_pos == '1))
        else $error("no-ORF result word malformed");

    // stop lies whole codons after the start on either strand
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_frame != FRAME_NONE) |-> (o_length_codons != '0)
                                              && (w_span == w_three_len))
        else $error("ORF span disagrees with codon length");

endmodule

bind longest_orf_six_frame_scan lorf_checker u_lorf_checker (.*);

// File: bench/orf_result_checker.sv
// Watches the byte and result channels of the six-frame ORF scanner, predicts each result word
// and compares it field by field. Depends on lorf_pkg for widths, the case mask and base codes.
module orf_result_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [7:0]                          i_nucleotide,
    input  logic                                i_is_last,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic                                i_strand,
    input  logic signed [lorf_pkg::FRAME_W-1:0] i_frame,
    input  logic signed [lorf_pkg::OPOS_W-1:0]  i_start_pos,
    input  logic signed [lorf_pkg::OPOS_W-1:0]  i_end_pos,
    input  logic [lorf_pkg::OLEN_W-1:0]         i_length_codons,
    input  logic                                i_too_long,
    output int                                  o_mismatches,
    output int                                  o_outstanding,
    output int                                  o_results
);
    import lorf_pkg::*;

    typedef struct {
        logic                      strand;
        logic signed [FRAME_W-1:0] frame;
        logic signed [OPOS_W-1:0]  start_pos;
        logic signed [OPOS_W-1:0]  end_pos;
        logic [OLEN_W-1:0]         length_codons;
        logic                      too_long;
    } orf_result_t;

    orf_result_t expected_orfs[$];
    int          mismatch_count;
    int          pending_count;
    int          result_count;

    // Scan state of the sequence in flight; reverse positions kept in forward coordinates.
    logic [7:0] older_base;
    logic [7:0] newer_base;
    int         seq_len;
    int         phase;
    int         fwd_open[3];
    int         fwd_len[3];
    int         fwd_start[3];
    int         fwd_stop[3];
    int         rc_stop[3];
    int         rc_cat[3];
    int         rc_len[3];
    int         rc_start[3];
    int         rc_end[3];
    bit         overflow;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = pending_count;
    assign o_results     = result_count;

    function automatic void restart_scan();
        older_base = '0;
        newer_base = '0;
        seq_len    = 0;
        phase      = 0;
        overflow   = 0;
        for (int f = 0; f < 3; f++) begin
            fwd_open[f]  = -1;
            fwd_len[f]   = 0;
            fwd_start[f] = 0;
            fwd_stop[f]  = 0;
            rc_stop[f]   = -1;
            rc_cat[f]    = -1;
            rc_len[f]    = 0;
            rc_start[f]  = 0;
            rc_end[f]    = 0;
        end
    endfunction

    // Later segments win ties: reading the reverse strand they come first.
    function automatic void close_segment(int q);
        int seg;
        if (rc_stop[q] >= 0 && rc_cat[q] >= 0) begin
            seg = (rc_cat[q] - rc_stop[q]) / 3;
            if (seg >= rc_len[q]) begin
                rc_len[q]   = seg;
                rc_start[q] = rc_cat[q];
                rc_end[q]   = rc_stop[q];
            end
        end
    endfunction

    function automatic void predict_byte(logic [7:0] raw, logic is_final);
        logic [7:0]  b;
        logic [7:0]  c0;
        logic [7:0]  c1;
        int          q;
        int          pos;
        int          span;
        int          best_len;
        int          best_start;
        int          best_stop;
        int          best_frame;
        int          r;
        bit          best_strand;
        orf_result_t res;

        b = raw & CASE_MASK;
        if (seq_len >= MAX_SEQ_LEN) begin
            overflow = 1;
        end else begin
            if (seq_len >= 2) begin
                c0  = older_base;
                c1  = newer_base;
                q   = (phase + 1) % 3;
                pos = seq_len - 2;
                if (c0 == NT_A && c1 == NT_T && b == NT_G) begin
                    if (fwd_open[q] < 0)
                        fwd_open[q] = pos;
                end else if (c0 == NT_T && ((c1 == NT_A && (b == NT_A || b == NT_G)) ||
                                            (c1 == NT_G && b == NT_A))) begin
                    if (fwd_open[q] >= 0) begin
                        span = (pos - fwd_open[q]) / 3;
                        if (span > fwd_len[q]) begin
                            fwd_len[q]   = span;
                            fwd_start[q] = fwd_open[q];
                            fwd_stop[q]  = pos;
                        end
                    end
                    fwd_open[q] = -1;
                end
                if (c0 == NT_C && c1 == NT_A && b == NT_T) begin
                    rc_cat[q] = pos;
                end else if (b == NT_A && ((c0 == NT_T && (c1 == NT_T || c1 == NT_C)) ||
                                           (c0 == NT_C && c1 == NT_T))) begin
                    close_segment(q);
                    rc_stop[q] = pos;
                    rc_cat[q]  = -1;
                end
            end
            older_base = newer_base;
            newer_base = b;
            seq_len++;
            phase = (phase + 1) % 3;
        end

        if (is_final) begin
            for (int f = 0; f < 3; f++)
                close_segment(f);
            best_len    = 0;
            best_start  = -1;
            best_stop   = -1;
            best_frame  = -1;
            best_strand = 0;
            for (int f = 0; f < 3; f++) begin
                if (fwd_len[f] > best_len) begin
                    best_len    = fwd_len[f];
                    best_start  = fwd_start[f];
                    best_stop   = fwd_stop[f];
                    best_frame  = f;
                    best_strand = 0;
                end
            end
            // Reverse frame f reads from the end, so its phase depends on the length.
            for (int f = 0; f < 3; f++) begin
                r = (seq_len % 3 + 3 - f) % 3;
                if (rc_len[r] > best_len) begin
                    best_len    = rc_len[r];
                    best_start  = seq_len - 3 - rc_start[r];
                    best_stop   = seq_len - 3 - rc_end[r];
                    best_frame  = f;
                    best_strand = 1;
                end
            end
            res.strand        = best_strand;
            res.frame         = FRAME_W'(best_frame);
            res.start_pos     = OPOS_W'(best_start);
            res.end_pos       = OPOS_W'(best_stop);
            res.length_codons = OLEN_W'(best_len);
            res.too_long      = overflow;
            expected_orfs.push_back(res);
            pending_count++;
            restart_scan();
        end
    endfunction

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        orf_result_t want;
        if (!i_rst_n) begin
            restart_scan();
            expected_orfs.delete();
            pending_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_orfs.size() == 0) begin
                    $error("result word with no sequence awaiting one");
                    mismatch_count++;
                end else begin
                    want = expected_orfs.pop_front();
                    pending_count--;
                    result_count++;
                    check_field("strand", want.strand, i_strand);
                    check_field("frame", want.frame, i_frame);
                    check_field("start_pos", want.start_pos, i_start_pos);
                    check_field("end_pos", want.end_pos, i_end_pos);
                    check_field("length_codons", want.length_codons, i_length_codons);
                    check_field("too_long", want.too_long, i_too_long);
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_byte(i_nucleotide, i_is_last);
        end
    end

endmodule

// File: bench/testbench.sv
// Top of the six-frame ORF scanner bench: clock, reset, sequence stimulus and verdict.
// Depends on lorf_pkg, longest_orf_six_frame_scan and orf_result_checker.
module testbench;
    import lorf_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_BYTES = 1000;
    localparam int TOTAL_BYTES = 1100;
    localparam int MIN_SEQUENCES = 40;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic [7:0]                i_nucleotide;
    logic                      i_is_last;
    logic                      o_valid;
    logic                      i_stall;
    logic                      o_strand;
    logic signed [FRAME_W-1:0] o_frame;
    logic signed [OPOS_W-1:0]  o_start_pos;
    logic signed [OPOS_W-1:0]  o_end_pos;
    logic [OLEN_W-1:0]         o_length_codons;
    logic                      o_too_long;

    int mismatches;
    int outstanding;
    int results;
    int idle_cycles;
    int stall_left;
    int idle_pct;
    int bytes_sent;
    int seqs_sent;
    bit quiet;
    logic [7:0] seq_bytes[$];

    always #10 i_clk = ~i_clk;

    longest_orf_six_frame_scan DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_nucleotide   (i_nucleotide),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_strand       (o_strand),
        .o_frame        (o_frame),
        .o_start_pos    (o_start_pos),
        .o_end_pos      (o_end_pos),
        .o_length_codons(o_length_codons),
        .o_too_long     (o_too_long)
    );

    orf_result_checker result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_nucleotide   (i_nucleotide),
        .i_is_last      (i_is_last),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_strand       (o_strand),
        .i_frame        (o_frame),
        .i_start_pos    (o_start_pos),
        .i_end_pos      (o_end_pos),
        .i_length_codons(o_length_codons),
        .i_too_long     (o_too_long),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_results      (results)
    );

    // Give up when neither channel has moved a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side back-pressure in short bursts.
    always @(posedge i_clk) begin
        if (quiet || idle_pct == 0) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(1, 100) <= idle_pct) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] random_base();
        case ($urandom_range(0, 3))
            0:       return NT_A;
            1:       return NT_C;
            2:       return NT_G;
            default: return NT_T;
        endcase
    endfunction

    function automatic logic [7:0] any_case(logic [7:0] nt);
        return $urandom_range(0, 1) ? (nt | ~CASE_MASK) : nt;
    endfunction

    function automatic void add_codon(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        seq_bytes.push_back(any_case(a));
        seq_bytes.push_back(any_case(b));
        seq_bytes.push_back(any_case(c));
    endfunction

    // Offer one word and hold it until taken, with an occasional gap ahead of it.
    task automatic send_byte(logic [7:0] nt, logic is_final);
        int gap;
        gap = 0;
        if (!quiet && idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
            gap = $urandom_range(1, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_nucleotide <= nt;
        i_is_last    <= is_final;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_queued_sequence();
        foreach (seq_bytes[k])
            send_byte(seq_bytes[k], k == seq_bytes.size() - 1);
        seq_bytes.delete();
        seqs_sent++;
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++)
            seq_bytes.push_back(s[k]);
        send_queued_sequence();
    endtask

    // Mostly codon-aligned sequences rich in starts and stops on both strands; some noise.
    task automatic send_random_sequence();
        int n_codons;
        int pick;
        case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            default: idle_pct = 35;
        endcase
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) seq_bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 2)) seq_bytes.push_back(any_case(random_base()));
            n_codons = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(0, 12);
            repeat (n_codons) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    add_codon(NT_A, NT_T, NT_G);
                end else if (pick < 22) begin
                    case ($urandom_range(0, 2))
                        0:       add_codon(NT_T, NT_A, NT_A);
                        1:       add_codon(NT_T, NT_A, NT_G);
                        default: add_codon(NT_T, NT_G, NT_A);
                    endcase
                end else if (pick < 32) begin
                    add_codon(NT_C, NT_A, NT_T);
                end else if (pick < 42) begin
                    case ($urandom_range(0, 2))
                        0:       add_codon(NT_T, NT_T, NT_A);
                        1:       add_codon(NT_C, NT_T, NT_A);
                        default: add_codon(NT_T, NT_C, NT_A);
                    endcase
                end else if (pick < 92) begin
                    add_codon(random_base(), random_base(), random_base());
                end else begin
                    repeat (3) seq_bytes.push_back(8'($urandom));
                end
            end
        end
        if (seq_bytes.size() == 0)
            seq_bytes.push_back(any_case(random_base()));
        send_queued_sequence();
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_nucleotide <= '0;
        i_is_last    <= 1'b0;
        idle_pct     = 0;
        bytes_sent   = 0;
        seqs_sent    = 0;
        quiet        = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short sequences with extreme bytes, then a forward and a reverse ORF in mixed case.
        seq_bytes.push_back(8'hFF);
        send_queued_sequence();
        seq_bytes.push_back(8'h00);
        seq_bytes.push_back(8'h80);
        send_queued_sequence();
        send_text("aTGccctga");
        send_text("TTAgggCAT");

        while (bytes_sent < RANDOM_BYTES || seqs_sent < MIN_SEQUENCES)
            send_random_sequence();

        // Closing stretch at full rate on both channels.
        quiet    = 1;
        idle_pct = 0;
        while (bytes_sent < TOTAL_BYTES)
            send_random_sequence();
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d sequences (%0d bytes) with random gaps and back-pressure,",
                 seqs_sent, bytes_sent);
        $display("ending at full rate; checked %0d result words.", results);
        if (mismatches == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
